[rtl/wsw_pkg.sv]
// weekday schedule window: shared types, constants and helper functions
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package wsw_pkg;

    // field widths
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 6;
    localparam int WDAY_W     = 3;
    localparam int MASK_W     = 7;
    localparam int DAY_MIN_W  = 11;
    localparam int DAY_SEC_W  = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    // clamp limits and calendar constants
    localparam logic [HOUR_W-1:0]    HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0]  MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0]  SECOND_MAX = 6'd59;
    localparam logic [DAY_SEC_W-1:0] SECONDS_PER_DAY = 17'd86400;
    localparam logic [WDAY_W-1:0]    WDAY_SUNDAY   = 3'd0;
    localparam logic [WDAY_W-1:0]    WDAY_SATURDAY = 3'd6;
    localparam logic [WDAY_W-1:0]    WDAY_NONE     = 3'd7;

    // queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // remainder pipeline: stages times steps covers the dividend plus a leading zero
    localparam int DIV_STAGES = 6;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_NUM_W  = DIV_STAGES * DIV_STEPS;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_WINDOW = 2'd1,
        MODE_DAILY  = 2'd2,
        MODE_CYCLIC = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_DAY_MASK     = 3'd1,
        CFG_WIN_START    = 3'd2,
        CFG_WIN_STOP     = 3'd3,
        CFG_DAILY_START  = 3'd4,
        CFG_ON_SECONDS   = 3'd5,
        CFG_PERIOD       = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        mode_t                 mode;
        logic [MASK_W-1:0]     day_mask;
        logic [DAY_MIN_W-1:0]  win_start;
        logic [DAY_MIN_W-1:0]  win_stop;
        logic [DAY_MIN_W-1:0]  daily_start;
        logic [DAY_SEC_W-1:0]  on_sec;
        logic [DAY_SEC_W-1:0]  period_sec;
    } cfg_t;

    // classified query as it travels from front to back
    typedef struct packed {
        logic [DAY_MIN_W-1:0] now_min;
        logic [DAY_SEC_W-1:0] now_sec;
        logic                 today;
        logic                 yest;
    } item_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    // x * 60 as shift and subtract
    function automatic logic [DAY_SEC_W-1:0] mul60(input logic [DAY_SEC_W-1:0] x);
        return (x << 6) - (x << 2);
    endfunction

    // one restoring step of a remainder
    function automatic logic [DAY_SEC_W-1:0] div_step(
        input logic [DAY_SEC_W-1:0] rem,
        input logic                 nbit,
        input logic [DAY_SEC_W-1:0] divisor
    );
        logic [DAY_SEC_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
        end
        return t[DAY_SEC_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/weekday_schedule_window_core.sv]
// weekday schedule window core: an accepted s_ beat reaches m_tvalid through the queue write,
// six remainder stages and the output register when the queue is empty
// throughput one beat per cycle while m_tready does not hold the output, set by the six-stage
// remainder pipeline that reduces the time of day and the day length by the cycle period
// reset (aresetn low, synchronous) clears the config registers to zero and empties the
// queue and pipeline; no clearing pass, s_tready is high as soon as the queue is cleared
`timescale 1ns / 1ps
`default_nettype none

module weekday_schedule_window_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [wsw_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [wsw_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // query stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // hour [4:0], minute [10:5], second [16:11], weekday [19:17], zero pad
    input  wire logic [wsw_pkg::S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // active [0], zero pad
    output logic [wsw_pkg::M_TDATA_W-1:0]       m_tdata
);
    import wsw_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   push_item, pop_item;
    logic    push_valid, push_ready;
    logic    pop_valid, pop_ready;
    q_stat_t q_stat;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MODE:        cfg_next.mode        = mode_t'(cfg_wr_data[1:0]);
                CFG_DAY_MASK:    cfg_next.day_mask    = cfg_wr_data[MASK_W-1:0];
                CFG_WIN_START:   cfg_next.win_start   = cfg_wr_data[DAY_MIN_W-1:0];
                CFG_WIN_STOP:    cfg_next.win_stop    = cfg_wr_data[DAY_MIN_W-1:0];
                CFG_DAILY_START: cfg_next.daily_start = cfg_wr_data[DAY_MIN_W-1:0];
                CFG_ON_SECONDS:  cfg_next.on_sec      = cfg_wr_data[DAY_SEC_W-1:0];
                CFG_PERIOD:      cfg_next.period_sec  = cfg_wr_data[DAY_SEC_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: clamp time fields, form minute and second of day, pick day bits
    wsw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .day_mask   (cfg_reg.day_mask),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decouples the front from back-pressure on the result side
    wsw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .stat       (q_stat)
    );

    // back: remainder pipeline, mode decision, output register
    wsw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // queue occupancy never goes beyond its depth
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // full and empty flags never both set
    a_q_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // a push without a pop grows the queue by exactly one beat
    a_q_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.push && !q_stat.pop) |=> q_stat.count == $past(q_stat.count) + 1'b1)
        else $error("queue count did not follow push");

    // a pop without a push shrinks the queue by exactly one beat
    a_q_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.pop && !q_stat.push) |=> q_stat.count == $past(q_stat.count) - 1'b1)
        else $error("queue count did not follow pop");
`endif

endmodule

`default_nettype wire

[rtl/wsw_front.sv]
// front: accepts query beats, clamps the time fields and looks up the day bits
// depends on wsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsw_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // hour [4:0], minute [10:5], second [16:11], weekday [19:17], zero pad
    input  wire logic [wsw_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [wsw_pkg::MASK_W-1:0]    day_mask,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output wsw_pkg::item_t                     push_item
);
    import wsw_pkg::*;

    logic [HOUR_W-1:0]    hour_in;
    logic [MINUTE_W-1:0]  minute_in;
    logic [SECOND_W-1:0]  second_in;
    logic [WDAY_W-1:0]    wday_in;
    logic [HOUR_W-1:0]    hour_c;
    logic [MINUTE_W-1:0]  minute_c;
    logic [SECOND_W-1:0]  second_c;
    logic [WDAY_W-1:0]    yest_day;
    logic [MASK_W:0]      mask_ext;
    logic [DAY_SEC_W-1:0] hour_min;
    logic [DAY_MIN_W-1:0] now_min;
    logic [DAY_SEC_W-1:0] min_sec;

    assign hour_in   = s_tdata[HOUR_W-1:0];
    assign minute_in = s_tdata[HOUR_W+MINUTE_W-1:HOUR_W];
    assign second_in = s_tdata[HOUR_W+MINUTE_W+SECOND_W-1:HOUR_W+MINUTE_W];
    assign wday_in   = s_tdata[HOUR_W+MINUTE_W+SECOND_W+WDAY_W-1:HOUR_W+MINUTE_W+SECOND_W];

    assign hour_c   = (hour_in > HOUR_MAX) ? HOUR_MAX : hour_in;
    assign minute_c = (minute_in > MINUTE_MAX) ? MINUTE_MAX : minute_in;
    assign second_c = (second_in > SECOND_MAX) ? SECOND_MAX : second_in;

    assign hour_min = mul60(DAY_SEC_W'(hour_c));
    assign now_min  = hour_min[DAY_MIN_W-1:0] + DAY_MIN_W'(minute_c);
    assign min_sec  = mul60(DAY_SEC_W'(now_min));

    // top bit stands for the missing weekday and always reads 0
    assign mask_ext = {1'b0, day_mask};
    assign yest_day = (wday_in == WDAY_NONE)   ? WDAY_NONE :
                      (wday_in == WDAY_SUNDAY) ? WDAY_SATURDAY : wday_in - 3'd1;

    assign push_item.now_min = now_min;
    assign push_item.now_sec = min_sec + DAY_SEC_W'(second_c);
    assign push_item.today   = mask_ext[wday_in];
    assign push_item.yest    = mask_ext[yest_day];

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

`default_nettype wire

[rtl/wsw_queue.sv]
// small queue of classified queries between front and back
// depends on wsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsw_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire wsw_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output wsw_pkg::item_t      pop_item,
    output wsw_pkg::q_stat_t    stat
);
    import wsw_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              full, empty, push, pop;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign push  = push_valid && !full;
    assign pop   = pop_ready && !empty;

    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign stat.push  = push;
    assign stat.pop   = pop;
    assign stat.full  = full;
    assign stat.empty = empty;
    assign stat.count = count_reg;

endmodule

`default_nettype wire

[rtl/wsw_back.sv]
// back: pipelined remainder by the cycle period, mode decision and output register
// depends on wsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsw_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire wsw_pkg::cfg_t                 cfg,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire wsw_pkg::item_t                pop_item,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // active [0], zero pad
    output logic [wsw_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wsw_pkg::*;

    // lane a: now_sec mod period, lane b: seconds per day mod period
    typedef struct packed {
        item_t                item;
        logic [DIV_NUM_W-1:0] num_a;
        logic [DIV_NUM_W-1:0] num_b;
        logic [DAY_SEC_W-1:0] rem_a;
        logic [DAY_SEC_W-1:0] rem_b;
    } stage_t;

    stage_t stg_reg  [DIV_STAGES];
    stage_t stg_src  [DIV_STAGES];
    stage_t stg_next [DIV_STAGES];
    logic   vld_reg  [DIV_STAGES];
    logic   vld_in   [DIV_STAGES];
    logic   rdy      [DIV_STAGES+1];

    logic m_tvalid_reg;
    logic active_reg, active_next;

    function automatic logic decide(input cfg_t c, input stage_t s);
        logic [DAY_SEC_W-1:0] open_sec;
        logic [DAY_SEC_W:0]   close_sec;
        logic [DAY_SEC_W-1:0] phase;
        logic                 on;
        open_sec  = mul60(DAY_SEC_W'(c.daily_start));
        close_sec = {1'b0, open_sec} + {1'b0, c.on_sec};
        phase     = s.rem_b;
        on        = 1'b0;
        case (c.mode)
            MODE_OFF: begin
                on = 1'b0;
            end
            MODE_WINDOW: begin
                if (c.win_start < c.win_stop) begin
                    on = s.item.today && s.item.now_min >= c.win_start
                         && s.item.now_min < c.win_stop;
                end else if (c.win_start > c.win_stop) begin
                    on = (s.item.today && s.item.now_min >= c.win_start)
                         || (s.item.yest && s.item.now_min < c.win_stop);
                end else begin
                    on = 1'b0;
                end
            end
            MODE_DAILY: begin
                if (close_sec <= {1'b0, SECONDS_PER_DAY}) begin
                    on = s.item.today && s.item.now_sec >= open_sec
                         && {1'b0, s.item.now_sec} < close_sec;
                end else begin
                    // part past midnight belongs to yesterday
                    on = (s.item.today && s.item.now_sec >= open_sec)
                         || (s.item.yest && {1'b0, s.item.now_sec}
                             < close_sec - {1'b0, SECONDS_PER_DAY});
                end
            end
            MODE_CYCLIC: begin
                if (c.period_sec == '0) begin
                    on = 1'b0;
                end else begin
                    on = (s.item.today && s.rem_a < c.on_sec)
                         || (phase != '0 && phase < c.on_sec && s.item.yest
                             && s.item.now_sec < c.on_sec - phase);
                end
            end
            default: begin
                on = 1'b0;
            end
        endcase
        return on;
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign stg_src[k].item  = pop_item;
            assign stg_src[k].num_a = DIV_NUM_W'(pop_item.now_sec);
            assign stg_src[k].num_b = DIV_NUM_W'(SECONDS_PER_DAY);
            assign stg_src[k].rem_a = '0;
            assign stg_src[k].rem_b = '0;
            assign vld_in[k]        = pop_valid;
        end else begin : g_rest
            assign stg_src[k] = stg_reg[k-1];
            assign vld_in[k]  = vld_reg[k-1];
        end

        always_comb begin
            stg_next[k] = stg_src[k];
            for (int j = 0; j < DIV_STEPS; j++) begin
                stg_next[k].rem_a = div_step(stg_next[k].rem_a,
                                             stg_next[k].num_a[DIV_NUM_W-1],
                                             cfg.period_sec);
                stg_next[k].rem_b = div_step(stg_next[k].rem_b,
                                             stg_next[k].num_b[DIV_NUM_W-1],
                                             cfg.period_sec);
                stg_next[k].num_a = stg_next[k].num_a << 1;
                stg_next[k].num_b = stg_next[k].num_b << 1;
            end
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && vld_in[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign rdy[DIV_STAGES] = !m_tvalid_reg || m_tready;
    assign pop_ready       = rdy[0];
    assign active_next     = decide(cfg, stg_reg[DIV_STAGES-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rdy[DIV_STAGES]) begin
            m_tvalid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[DIV_STAGES] && vld_reg[DIV_STAGES-1]) begin
            active_reg <= active_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(active_reg);

endmodule

`default_nettype wire

[verif/wsw_schedule_checker.sv]
// schedule checker: watches the config port and both streams of the weekly timer core,
// predicts the active flag of every query beat and compares results in order
// depends on wsw_pkg for field widths, config indexes and the mode enum
`timescale 1ns / 1ps

module wsw_schedule_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wsw_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wsw_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [wsw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [wsw_pkg::M_TDATA_W-1:0]  m_tdata,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);
    import wsw_pkg::*;

    localparam int unsigned DAY_SECONDS = 86400;
    localparam int unsigned MAX_REPORTS = 10;

    cfg_t                 sched_cfg;
    logic [M_TDATA_W-1:0] active_expected [$];

    // on/off decision for one query beat under the current register copy
    function automatic logic schedule_on(input logic [S_TDATA_W-1:0] d);
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mn;
        logic [SECOND_W-1:0] sc;
        logic [WDAY_W-1:0]   wd;
        logic                today_on;
        logic                prev_on;
        int unsigned         now_min;
        int unsigned         now_sec;
        int unsigned         open_sec;
        int unsigned         close_sec;
        int unsigned         spill;
        hr = d[4:0];
        mn = d[10:5];
        sc = d[16:11];
        wd = d[19:17];
        if (hr > HOUR_MAX) hr = HOUR_MAX;
        if (mn > MINUTE_MAX) mn = MINUTE_MAX;
        if (sc > SECOND_MAX) sc = SECOND_MAX;
        today_on = 1'b0;
        prev_on  = 1'b0;
        if (wd != WDAY_NONE) begin
            today_on = sched_cfg.day_mask[wd];
            prev_on  = (wd == WDAY_SUNDAY) ? sched_cfg.day_mask[WDAY_SATURDAY]
                                           : sched_cfg.day_mask[wd - 1];
        end
        now_min = int'(hr) * 60 + int'(mn);
        now_sec = now_min * 60 + int'(sc);
        case (sched_cfg.mode)
            MODE_OFF: begin
                return 1'b0;
            end
            MODE_WINDOW: begin
                if (sched_cfg.win_start < sched_cfg.win_stop) begin
                    return today_on && now_min >= sched_cfg.win_start &&
                           now_min < sched_cfg.win_stop;
                end else if (sched_cfg.win_start > sched_cfg.win_stop) begin
                    return (today_on && now_min >= sched_cfg.win_start) ||
                           (prev_on && now_min < sched_cfg.win_stop);
                end
                return 1'b0;
            end
            MODE_DAILY: begin
                open_sec  = int'(sched_cfg.daily_start) * 60;
                close_sec = open_sec + int'(sched_cfg.on_sec);
                if (close_sec <= DAY_SECONDS) begin
                    return today_on && now_sec >= open_sec && now_sec < close_sec;
                end
                return (today_on && now_sec >= open_sec) ||
                       (prev_on && now_sec < close_sec - DAY_SECONDS);
            end
            default: begin
                if (sched_cfg.period_sec == '0) return 1'b0;
                if (today_on && (now_sec % int'(sched_cfg.period_sec)) < sched_cfg.on_sec) begin
                    return 1'b1;
                end
                spill = DAY_SECONDS % int'(sched_cfg.period_sec);
                return spill > 0 && spill < sched_cfg.on_sec && prev_on &&
                       now_sec < int'(sched_cfg.on_sec) - spill;
            end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        logic [M_TDATA_W-1:0] want;
        if (!aresetn) begin
            sched_cfg <= '0;
            active_expected.delete();
            pending = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_MODE:        sched_cfg.mode        <= mode_t'(cfg_wr_data[1:0]);
                    CFG_DAY_MASK:    sched_cfg.day_mask    <= cfg_wr_data[MASK_W-1:0];
                    CFG_WIN_START:   sched_cfg.win_start   <= cfg_wr_data[DAY_MIN_W-1:0];
                    CFG_WIN_STOP:    sched_cfg.win_stop    <= cfg_wr_data[DAY_MIN_W-1:0];
                    CFG_DAILY_START: sched_cfg.daily_start <= cfg_wr_data[DAY_MIN_W-1:0];
                    CFG_ON_SECONDS:  sched_cfg.on_sec      <= cfg_wr_data[DAY_SEC_W-1:0];
                    CFG_PERIOD:      sched_cfg.period_sec  <= cfg_wr_data[DAY_SEC_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                active_expected.push_back(M_TDATA_W'(schedule_on(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                if (active_expected.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("result beat with nothing expected: m_tdata %h", m_tdata);
                    end
                    fail_count++;
                end else begin
                    want = active_expected.pop_front();
                    if (m_tdata !== want) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("active mismatch: expected %h got %h", want, m_tdata);
                        end
                        fail_count++;
                    end
                end
            end
            pending = active_expected.size();
        end
    end

endmodule

[verif/testbench.sv]
// top of the weekly timer core bench: clock, reset, query and config stimulus,
// result back-pressure, watchdog and verdict; checking lives in wsw_schedule_checker
// depends on wsw_pkg, weekday_schedule_window_core and wsw_schedule_checker
`timescale 1ns / 1ps

module testbench;
    import wsw_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 12;   // lets the core pipeline run empty, plus slack
    localparam int HOLD_CYCLES     = 150;  // long receiver hold-off to fill the core
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 60;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = CFG_MODE;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // hour [4:0], minute [10:5], second [16:11], weekday [19:17], zero pad
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // active [0], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned stall_cycles = 0;

    // query beat taken at the last rising edge, looked at on the falling edge
    logic s_fire_q = 1'b0;

    // handshake between stimulus and receiver for the long hold-off
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    // register values last written, used to aim queries at schedule edges
    int unsigned cur_ws, cur_we, cur_ds, cur_on, cur_per;

    always #1 aclk = ~aclk;

    weekday_schedule_window_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    wsw_schedule_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge aclk) begin
        s_fire_q <= aresetn && s_tvalid && s_tready;
    end

    // watchdog: any accepted beat on either side counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    // pack one query, fields taken at their port widths
    function automatic logic [S_TDATA_W-1:0] pack_time(int unsigned hr, int unsigned mn,
                                                      int unsigned sc, int unsigned wd);
        return {4'b0, wd[WDAY_W-1:0], sc[SECOND_W-1:0], mn[MINUTE_W-1:0], hr[HOUR_W-1:0]};
    endfunction

    // mostly legal times, a share aimed at the edges of the current schedule,
    // and some with every field bit free (clamped hours, weekday 7)
    function automatic logic [S_TDATA_W-1:0] random_query();
        int unsigned pick;
        int unsigned t;
        int unsigned wd;
        pick = $urandom_range(0, 99);
        wd   = $urandom_range(0, 6);
        if (pick < 15) begin
            return pack_time($urandom_range(0, 31), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 7));
        end
        if (pick < 50) begin
            case ($urandom_range(0, 5))
                0: t = cur_ws * 60;
                1: t = cur_we * 60;
                2: t = cur_ds * 60;
                3: t = cur_ds * 60 + cur_on;
                4: t = (cur_per != 0) ?
                       ($urandom % (86400 / cur_per + 1)) * cur_per + cur_on : cur_on;
                default: t = (cur_per != 0 && cur_on > 86400 % cur_per) ?
                             cur_on - 86400 % cur_per : 0;
            endcase
            t = (t + 86400 + $urandom_range(0, 4) - 2) % 86400;
            return pack_time(t / 3600, (t / 60) % 60, t % 60, wd);
        end
        return pack_time($urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59), wd);
    endfunction

    function automatic int unsigned random_minute();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1439;
            2:       return $urandom_range(1440, 2047);  // above range, used as given
            default: return $urandom_range(0, 1439);
        endcase
    endfunction

    function automatic int unsigned random_seconds();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 86400;
            2:       return $urandom_range(86401, 131071);
            3:       return $urandom_range(1, 120);
            default: return $urandom_range(0, 86400);
        endcase
    endfunction

    // one register write per cycle, enable held across back-to-back writes
    task automatic write_reg(cfg_idx_t idx, int unsigned val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
    endtask

    task automatic set_config(mode_t md, int unsigned mask, int unsigned ws, int unsigned we,
                              int unsigned ds, int unsigned on, int unsigned per);
        write_reg(CFG_MODE, md);
        write_reg(CFG_DAY_MASK, mask);
        write_reg(CFG_WIN_START, ws);
        write_reg(CFG_WIN_STOP, we);
        write_reg(CFG_DAILY_START, ds);
        write_reg(CFG_ON_SECONDS, on);
        write_reg(CFG_PERIOD, per);
        cfg_wr_en <= 1'b0;
        cur_ws  = ws;
        cur_we  = we;
        cur_ds  = ds;
        cur_on  = on;
        cur_per = per;
    endtask

    task automatic random_config();
        mode_t       md;
        int unsigned mask;
        int unsigned ws;
        int unsigned we;
        md = mode_t'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
        case ($urandom_range(0, 9))
            0:       mask = 0;
            1:       mask = 7'h7f;
            default: mask = $urandom_range(0, 127);
        endcase
        ws = random_minute();
        we = ($urandom_range(0, 7) == 0) ? ws : random_minute();  // empty window now and then
        set_config(md, mask, ws, we, random_minute(), random_seconds(), random_seconds());
    endtask

    // offer one beat and hold it until taken; returns on the falling edge after the
    // accepting rising edge with tvalid still high
    task automatic send_query(logic [S_TDATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do begin
            @(negedge aclk);
        end while (!s_fire_q);
    endtask

    // sender gap, noise on tdata while not valid
    task automatic idle_gap(int unsigned n);
        s_tvalid <= 1'b0;
        s_tdata  <= S_TDATA_W'($urandom);
        repeat (n) @(negedge aclk);
    endtask

    // wait for every expected beat, then let the pipeline run empty
    task automatic drain();
        idle_gap(1);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // receiver: segments of different stall styles, plus one long hold-off on request
    initial begin : receiver
        int unsigned style;
        int unsigned seg;
        int unsigned tick;
        tick = 0;
        do begin
            @(negedge aclk);
        end while (!aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            style = $urandom_range(0, 3);
            seg   = $urandom_range(20, 200);
            repeat (seg) begin
                // a pending hold-off request starts right away
                if (hold_req && !hold_done) break;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 == 0);
                endcase
                tick++;
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned i;
        int unsigned burst;
        bit          gapless;
        cur_ws  = 0;
        cur_we  = 0;
        cur_ds  = 0;
        cur_on  = 0;
        cur_per = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // registers as after reset: disabled
        send_query(pack_time(23, 59, 59, 6));
        send_query(pack_time(0, 0, 0, 0));
        drain();

        // plain window 08:00 to 17:00, stop minute excluded
        set_config(MODE_WINDOW, 7'h7f, 480, 1020, 0, 0, 0);
        send_query(pack_time(7, 59, 59, 1));
        send_query(pack_time(8, 0, 0, 1));
        send_query(pack_time(16, 59, 59, 1));
        send_query(pack_time(17, 0, 0, 1));
        send_query(pack_time(12, 0, 0, 7));   // no weekday
        send_query(pack_time(12, 63, 0, 2));  // minute clamps to 59
        drain();

        // window wrapping midnight, monday only: after midnight follows monday
        set_config(MODE_WINDOW, 7'h02, 1320, 360, 0, 0, 0);
        send_query(pack_time(23, 0, 0, 1));
        send_query(pack_time(2, 0, 0, 2));
        send_query(pack_time(2, 0, 0, 1));
        send_query(pack_time(23, 0, 0, 2));
        drain();

        // equal start and stop: empty window
        set_config(MODE_WINDOW, 7'h7f, 600, 600, 0, 0, 0);
        send_query(pack_time(10, 0, 0, 3));
        drain();

        // daily 23:00 for two hours, saturday only: split across midnight
        set_config(MODE_DAILY, 7'h40, 0, 0, 1380, 7200, 0);
        send_query(pack_time(23, 30, 0, 6));
        send_query(pack_time(0, 59, 59, 0));
        send_query(pack_time(1, 0, 0, 0));
        send_query(pack_time(23, 30, 0, 5));
        drain();

        // daily whole day, all field bits set clamp to 23:59:59
        set_config(MODE_DAILY, 7'h7f, 0, 0, 0, 86400, 0);
        send_query(pack_time(0, 0, 0, 0));
        send_query(pack_time(31, 63, 63, 3));
        send_query(pack_time(31, 63, 63, 7));
        drain();

        // cyclic with spillover from monday's last cycle into tuesday
        set_config(MODE_CYCLIC, 7'h02, 0, 0, 0, 3000, 7000);
        send_query(pack_time(0, 5, 0, 2));
        send_query(pack_time(0, 10, 0, 2));
        send_query(pack_time(0, 5, 0, 1));
        drain();

        // cyclic with period zero: off
        set_config(MODE_CYCLIC, 7'h7f, 0, 0, 0, 3000, 0);
        send_query(pack_time(0, 0, 0, 4));
        drain();

        // disabled with everything else set
        set_config(MODE_OFF, 7'h7f, 0, 1439, 0, 86400, 86400);
        send_query(pack_time(12, 0, 0, 4));
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       set_config(MODE_CYCLIC, 7'h7f, 1439, 1439, 1439, 86400, 86400);
                1:       set_config(MODE_DAILY, 7'h7f, 2047, 0, 2047, 131071, 131071);
                2: begin
                    hold_req = 1'b1;   // receiver holds off while beats keep coming
                    random_config();
                end
                3:       set_config(MODE_WINDOW, 0, 0, 1439, 0, 0, 1);
                4:       set_config(MODE_CYCLIC, 7'h7f, 0, 0, 0, 131071, 131071);
                default: random_config();
            endcase
            gapless = (ph == 2) || ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(1, 30);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_query(random_query());
                if (!gapless) begin
                    burst--;
                    if (burst == 0) begin
                        idle_gap($urandom_range(1, 12));
                        burst = $urandom_range(1, 30);
                    end
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
